// ===== hdl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants for the life grid generation step
// Grid geometry, command and result word layouts, control struct
// ----------------------------------------------------------------------------
package lgs_pkg;

    // grid geometry
    localparam int GRID_SIZE = 16;
    localparam int ROW_W     = 16;
    localparam int IDX_W     = 4;

    // life rule constants
    localparam logic [3:0] LIFE_BIRTH   = 4'd3;
    localparam logic [3:0] LIFE_KEEP_LO = 4'd2;

    // last row of the grid as an index
    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(GRID_SIZE - 1);

    // action codes
    typedef enum logic {
        ACT_WRITE   = 1'b0,
        ACT_ADVANCE = 1'b1
    } t_action;

    // command word
    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [IDX_W-1:0] out_row_index;
        logic [ROW_W-1:0] out_row_bits;
        logic             last_row;
    } t_out_word;

    // row store control
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             shift_en;
    } t_store_ctl;

endpackage

// ===== hdl/lgs_row_rule.sv =====
// ----------------------------------------------------------------------------
// lgs_row_rule: one row of the life rule
// New cells of a row from the rows above, at and below it, dead past the edges
// ----------------------------------------------------------------------------
module lgs_row_rule (
    input  logic [lgs_pkg::ROW_W-1:0] i_above,
    input  logic [lgs_pkg::ROW_W-1:0] i_cur,
    input  logic [lgs_pkg::ROW_W-1:0] i_below,
    output logic [lgs_pkg::ROW_W-1:0] o_next
);
    import lgs_pkg::*;

    logic [ROW_W+1:0] w_above;
    logic [ROW_W+1:0] w_cur;
    logic [ROW_W+1:0] w_below;

    // pad one dead cell on each side
    assign w_above = {1'b0, i_above, 1'b0};
    assign w_cur   = {1'b0, i_cur,   1'b0};
    assign w_below = {1'b0, i_below, 1'b0};

    // one lane per column: neighbour count and rule
    always_comb begin
        logic [3:0] n;
        for (int c = 0; c < ROW_W; c++) begin
            n = 4'(w_above[c]) + 4'(w_above[c+1]) + 4'(w_above[c+2])
              + 4'(w_cur[c])                      + 4'(w_cur[c+2])
              + 4'(w_below[c]) + 4'(w_below[c+1]) + 4'(w_below[c+2]);
            o_next[c] = (n == LIFE_BIRTH) || (i_cur[c] && (n == LIFE_KEEP_LO));
        end
    end

endmodule

// ===== hdl/lgs_row_store.sv =====
// ----------------------------------------------------------------------------
// lgs_row_store: grid held as a shift register of rows
// Rows are written by index and rotate one row per cycle during a generation
// ----------------------------------------------------------------------------
module lgs_row_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lgs_pkg::t_store_ctl       i_ctl,
    input  logic [lgs_pkg::ROW_W-1:0] i_wr_row,
    input  logic [lgs_pkg::ROW_W-1:0] i_shift_row,
    output logic [lgs_pkg::ROW_W-1:0] o_head,
    output logic [lgs_pkg::ROW_W-1:0] o_next_head
);
    import lgs_pkg::*;

    logic [ROW_W-1:0] r_rows [GRID_SIZE];

    // row writes and rotation, new rows enter at the tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GRID_SIZE; i++) r_rows[i] <= '0;
        end else if (i_ctl.shift_en) begin
            for (int i = 0; i < GRID_SIZE - 1; i++) r_rows[i] <= r_rows[i+1];
            r_rows[GRID_SIZE-1] <= i_shift_row;
        end else if (i_ctl.wr_en) begin
            r_rows[i_ctl.wr_idx] <= i_wr_row;
        end
    end

    assign o_head      = r_rows[0];
    assign o_next_head = r_rows[1];

endmodule

// ===== hdl/life_grid_generation_step.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step: Conway life grid, one generation per advance word
// Row writes load the grid; an advance computes and emits the new grid
// ----------------------------------------------------------------------------
// write word: no result, busy stays low
// advance word: busy until every row is computed, one row computed per cycle as the
// row shift register rotates; each new row appears registered on o_result,
// one per cycle, strobed, last row flagged
// next word accepted once busy falls
// synchronous active-low reset clears the grid to all dead and the control
module life_grid_generation_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lgs_pkg::t_in_word i_cmd,
    output logic              o_strobe,
    output lgs_pkg::t_out_word o_result
);
    import lgs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [ROW_W-1:0] r_prev;
    logic             r_strobe;
    t_out_word        r_result;

    t_store_ctl       w_ctl;
    logic [ROW_W-1:0] w_head, w_next_head;
    logic [ROW_W-1:0] w_above, w_below, w_new_row;
    logic             w_accept;

    assign w_accept = start && !busy;
    assign busy     = (r_state == S_RUN);

    // control sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd.action == ACT_ADVANCE)) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_ROW) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= busy;
        end
    end

    // row store control, writes past the grid are dropped
    always_comb begin
        w_ctl.wr_en    = w_accept && (i_cmd.action == ACT_WRITE)
                         && (int'(i_cmd.row_index) < GRID_SIZE);
        w_ctl.wr_idx   = i_cmd.row_index;
        w_ctl.shift_en = busy;
    end

    lgs_row_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_wr_row    (i_cmd.row_bits),
        .i_shift_row (w_new_row),
        .o_head      (w_head),
        .o_next_head (w_next_head)
    );

    // neighbour rows, dead beyond the top and bottom edges
    assign w_above = (r_cnt == '0)       ? '0 : r_prev;
    assign w_below = (r_cnt == LAST_ROW) ? '0 : w_next_head;

    lgs_row_rule u_rule (
        .i_above (w_above),
        .i_cur   (w_head),
        .i_below (w_below),
        .o_next  (w_new_row)
    );

    // old row kept as the row above, result word registered
    always_ff @(posedge i_clk) begin
        if (busy) begin
            r_prev                 <= w_head;
            r_result.out_row_index <= r_cnt;
            r_result.out_row_bits  <= w_new_row;
            r_result.last_row      <= (r_cnt == LAST_ROW);
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // a result only follows a compute cycle
    a_strobe_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_RUN))
        else $error("result strobe without a compute cycle");

    // an accepted advance makes the block busy
    a_advance_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.action == ACT_ADVANCE)) |=> busy)
        else $error("advance accepted but block not busy");

    // nothing follows the last row directly
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_row) |=> !o_strobe)
        else $error("result strobe after the last row");

    // rows are emitted in order
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_row) |=>
            (o_strobe && (o_result.out_row_index == $past(o_result.out_row_index) + 1'b1)))
        else $error("emitted rows out of order");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for life_grid_generation_step
// Drives row writes and generation advances through the start/busy handshake,
// keeps its own copy of the cell grid, steps it by the life rule on every
// accepted advance and checks each strobed row of the new grid in order.
// A short directed table comes first, then random episodes that load a
// pattern and let it evolve over up to four generations.
// ----------------------------------------------------------------------------
module tb_top;
    import lgs_pkg::*;

    // run shape
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_WORDS = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // life rule counts
    localparam int BIRTH_COUNT = 3;
    localparam int KEEP_MIN    = 2;
    localparam int KEEP_MAX    = 3;

    // how the rows of an advance are to be expected
    typedef struct {
        bit               typed;
        logic [ROW_W-1:0] rim_bits;
        logic [ROW_W-1:0] core_bits;
    } t_word_note;

    typedef struct {
        t_in_word   cmd;
        t_word_note note;
    } t_directed_row;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_in_word   i_cmd   = '0;
    logic       o_strobe;
    t_out_word  o_result;

    // predicted grid and pending results
    logic [ROW_W-1:0] life_cells [GRID_SIZE];
    t_out_word        pending_rows [$];
    t_word_note       word_notes [$];
    t_directed_row    directed_words [$];

    int fault_count = 0;
    int cycle_count = 0;

    life_grid_generation_step dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // word builder
    function automatic t_in_word make_word(input logic act, input logic [IDX_W-1:0] idx,
                                           input logic [ROW_W-1:0] bits);
        t_in_word w;
        w.action    = act;
        w.row_index = idx;
        w.row_bits  = bits;
        return w;
    endfunction

    // cell lookup, dead beyond the edges
    function automatic int cell_live(input int r, input int c);
        if (r < 0 || r >= GRID_SIZE || c < 0 || c >= GRID_SIZE) begin
            return 0;
        end
        return life_cells[r][c] ? 1 : 0;
    endfunction

    // one generation of the life rule over the whole grid
    function automatic void step_generation();
        logic [ROW_W-1:0] nxt [GRID_SIZE];
        int               n;
        logic             alive;
        for (int r = 0; r < GRID_SIZE; r++) begin
            nxt[r] = '0;
            for (int c = 0; c < GRID_SIZE; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            n += cell_live(r + dr, c + dc);
                        end
                    end
                end
                alive     = life_cells[r][c];
                nxt[r][c] = alive ? (n >= KEEP_MIN && n <= KEEP_MAX) : (n == BIRTH_COUNT);
            end
        end
        for (int r = 0; r < GRID_SIZE; r++) begin
            life_cells[r] = nxt[r];
        end
    endfunction

    // apply an accepted word to the grid and queue the rows it emits
    function automatic void absorb_word(input t_in_word w, input t_word_note note);
        t_out_word row;
        if (w.action == ACT_WRITE) begin
            if (int'(w.row_index) < GRID_SIZE) begin
                life_cells[w.row_index] = w.row_bits;
            end
        end else begin
            step_generation();
            for (int r = 0; r < GRID_SIZE; r++) begin
                row.out_row_index = IDX_W'(r);
                if (note.typed) begin
                    row.out_row_bits = (r == 0 || r == GRID_SIZE - 1) ? note.rim_bits
                                                                       : note.core_bits;
                end else begin
                    row.out_row_bits = life_cells[r];
                end
                row.last_row = (IDX_W'(r) == LAST_ROW);
                pending_rows.push_back(row);
            end
        end
    endfunction

    function automatic void report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    // result check and word acceptance, all on pre-edge values
    always @(posedge i_clk) begin
        t_out_word  want;
        t_word_note note;
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_SIZE; r++) begin
                life_cells[r] = '0;
            end
        end else begin
            if (o_strobe) begin
                if (pending_rows.size() == 0) begin
                    report_fault($sformatf("expected none, got row %0d bits %h last %b",
                                           o_result.out_row_index, o_result.out_row_bits,
                                           o_result.last_row));
                end else begin
                    want = pending_rows.pop_front();
                    if (o_result.out_row_index !== want.out_row_index ||
                        o_result.out_row_bits  !== want.out_row_bits  ||
                        o_result.last_row      !== want.last_row) begin
                        report_fault($sformatf(
                            "expected row %0d bits %h last %b, got row %0d bits %h last %b",
                            want.out_row_index, want.out_row_bits, want.last_row,
                            o_result.out_row_index, o_result.out_row_bits,
                            o_result.last_row));
                    end
                end
            end
            if (start && !busy) begin
                note = '{typed: 1'b0, rim_bits: '0, core_bits: '0};
                if (word_notes.size() != 0) begin
                    note = word_notes.pop_front();
                end
                absorb_word(i_cmd, note);
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // present a word and hold it until the block takes it
    task automatic send_word(input t_in_word w, input t_word_note note);
        word_notes.push_back(note);
        start <= 1'b1;
        i_cmd <= w;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // sender gap with junk on the command bus
    task automatic idle_cycles(input int n);
        start <= 1'b0;
        i_cmd <= make_word(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, GRID_SIZE - 1)),
                           ROW_W'($urandom_range(0, 16'hFFFF)));
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pace(input bit calm);
        if (!calm && $urandom_range(0, 3) == 0) begin
            idle_cycles($urandom_range(1, 10));
        end
    endtask

    // wait until every emitted row has been seen, the last word absorbed first
    task automatic drain_rows();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rows.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // row contents of assorted densities
    function automatic logic [ROW_W-1:0] random_row();
        case ($urandom_range(0, 6))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return ROW_W'($urandom & $urandom);
            end
            3: begin
                return ROW_W'($urandom | $urandom);
            end
            4: begin
                return ROW_W'(1) << $urandom_range(0, ROW_W - 1);
            end
            default: begin
                return ROW_W'($urandom);
            end
        endcase
    endfunction

    function automatic void add_entry(input t_in_word w, input bit typed,
                                      input logic [ROW_W-1:0] rim, input logic [ROW_W-1:0] core);
        t_directed_row e;
        e.cmd  = w;
        e.note = '{typed: typed, rim_bits: rim, core_bits: core};
        directed_words.push_back(e);
    endfunction

    // stimulus
    initial begin
        t_word_note plain;
        int         sent;
        bit         drained;
        bit         calm;
        int         n_adv;
        plain   = '{typed: 1'b0, rim_bits: '0, core_bits: '0};
        sent    = 0;
        drained = 1'b0;

        // directed table
        // empty grid after reset stays empty
        add_entry(make_word(ACT_ADVANCE, '1, '1), 1'b1, '0, '0);
        // full grid: only the corners survive, then they die alone
        for (int r = 0; r < GRID_SIZE; r++) begin
            add_entry(make_word(ACT_WRITE, IDX_W'(r), '1), 1'b0, '0, '0);
        end
        add_entry(make_word(ACT_ADVANCE, '0, '0), 1'b1, 16'h8001, '0);
        add_entry(make_word(ACT_ADVANCE, '0, '1), 1'b1, '0, '0);
        // blinker oscillates
        add_entry(make_word(ACT_WRITE, 4'd5, 16'h0070), 1'b0, '0, '0);
        add_entry(make_word(ACT_ADVANCE, '0, '0), 1'b0, '0, '0);
        add_entry(make_word(ACT_ADVANCE, '0, '0), 1'b0, '0, '0);
        // still block in the far corner, lone cell on the near edge
        add_entry(make_word(ACT_WRITE, 4'd14, 16'hC000), 1'b0, '0, '0);
        add_entry(make_word(ACT_WRITE, 4'd15, 16'hC000), 1'b0, '0, '0);
        add_entry(make_word(ACT_WRITE, 4'd0, 16'h0001), 1'b0, '0, '0);
        add_entry(make_word(ACT_ADVANCE, '1, '0), 1'b0, '0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < directed_words.size(); i++) begin
            pace(1'b0);
            send_word(directed_words[i].cmd, directed_words[i].note);
        end

        // random episodes: load a pattern, then let it evolve
        while (sent < RANDOM_WORDS) begin
            calm = (sent >= RANDOM_WORDS * 85 / 100);
            if (!drained && sent >= RANDOM_WORDS / 2) begin
                drain_rows();
                drained = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                for (int r = 0; r < GRID_SIZE; r++) begin
                    pace(calm);
                    send_word(make_word(ACT_WRITE, IDX_W'(r), random_row()), plain);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(0, 6)) begin
                    pace(calm);
                    send_word(make_word(ACT_WRITE,
                                        IDX_W'($urandom_range(0, GRID_SIZE - 1)),
                                        random_row()), plain);
                    sent++;
                end
            end
            n_adv = $urandom_range(0, 4);
            repeat (n_adv) begin
                pace(calm);
                send_word(make_word(ACT_ADVANCE, IDX_W'($urandom_range(0, GRID_SIZE - 1)),
                                    ROW_W'($urandom_range(0, 16'hFFFF))), plain);
                sent++;
            end
        end

        // let the last generation come out
        drain_rows();
        repeat (GRID_SIZE + 4) @(posedge i_clk);
        if (fault_count == 0 && pending_rows.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
